/* rtl/ir_distance_scan_converter_defines.svh */
// Assertion macros used by the checker file.
// Both expect signals named clock and reset in the scope of use.
`ifndef IR_DISTANCE_SCAN_CONVERTER_DEFINES_SVH
`define IR_DISTANCE_SCAN_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define IRDSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("irdsc assertion failed");

// Next-cycle implication, disabled while reset is high
`define IRDSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("irdsc assertion failed");

`endif

/* rtl/irdsc_pkg.sv */
package irdsc_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 10;
   localparam int DIST_W   = 8;
   localparam int MASK_W   = 4;
   localparam int CHAN_W   = 2;

   // Table and sensor geometry
   localparam int TABLE_POINTS = 14;
   localparam int SENSOR_COUNT = 4;
   localparam int PT_CNT_W     = $clog2(TABLE_POINTS + 1);
   localparam int SCAN_W       = $clog2(SENSOR_COUNT + 1);

   // Item function codes
   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [DIST_W-1:0] DIST_BELOW_RANGE = 8'd255;

   // Calibration readings, ascending
   function automatic logic [SAMPLE_W-1:0] pt_reading(input logic [PT_CNT_W-1:0] idx);
      logic [SAMPLE_W-1:0] r;
      unique case (idx)
         0:       r = 10'd60;
         1:       r = 10'd88;
         2:       r = 10'd107;
         3:       r = 10'd151;
         4:       r = 10'd165;
         5:       r = 10'd189;
         6:       r = 10'd215;
         7:       r = 10'd257;
         8:       r = 10'd287;
         9:       r = 10'd319;
         10:      r = 10'd360;
         11:      r = 10'd410;
         12:      r = 10'd480;
         13:      r = 10'd559;
         default: r = '1;
      endcase
      return r;
   endfunction

   // Calibration distances in cm, descending
   function automatic logic [DIST_W-1:0] pt_distance(input logic [PT_CNT_W-1:0] idx);
      logic [DIST_W-1:0] d;
      unique case (idx)
         0:       d = 8'd40;
         1:       d = 8'd30;
         2:       d = 8'd25;
         3:       d = 8'd20;
         4:       d = 8'd16;
         5:       d = 8'd14;
         6:       d = 8'd12;
         7:       d = 8'd10;
         8:       d = 8'd9;
         9:       d = 8'd8;
         10:      d = 8'd7;
         11:      d = 8'd6;
         12:      d = 8'd5;
         13:      d = 8'd4;
         default: d = 8'd4;
      endcase
      return d;
   endfunction

   // Widest reading step between neighboring points
   function automatic int max_gap();
      int m;
      int g;
      m = 0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         g = int'(pt_reading(PT_CNT_W'(i))) - int'(pt_reading(PT_CNT_W'(i - 1)));
         if (g > m) m = g;
      end
      return m;
   endfunction

   // Largest distance drop between neighboring points
   function automatic int max_drop();
      int m;
      int g;
      m = 0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         g = int'(pt_distance(PT_CNT_W'(i - 1))) - int'(pt_distance(PT_CNT_W'(i)));
         if (g > m) m = g;
      end
      return m;
   endfunction

   localparam int GAP_W     = $clog2(max_gap() + 1);
   localparam int DROP_W    = $clog2(max_drop() + 1);
   localparam int NUM_W     = GAP_W + DROP_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   // First enabled sensor at or above start, SENSOR_COUNT if none
   function automatic logic [SCAN_W-1:0] first_enabled(input logic [MASK_W-1:0] mask,
                                                      input logic [SCAN_W-1:0] start);
      logic [SCAN_W-1:0] res;
      res = SCAN_W'(SENSOR_COUNT);
      for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
         if ((SCAN_W'(i) >= start) && mask[i]) res = SCAN_W'(i);
      end
      return res;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_DIVIDE,
      ST_COMMIT
   } irdsc_state_type;

   typedef struct packed {
      logic load;
      logic search_step;
      logic mult;
      logic div_step;
      logic commit;
   } irdsc_cmd_type;

   typedef struct packed {
      logic skip;
      logic search_done;
      logic in_table;
      logic div_done;
   } irdsc_status_type;

endpackage

/* rtl/irdsc_if.sv */
interface irdsc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [irdsc_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, func, sample, input ready);
   modport sink   (input valid, func, sample, output ready);
endinterface

interface irdsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          channel_valid;
   logic [irdsc_pkg::CHAN_W-1:0]  next_channel;
   logic                          scan_done;
   logic                          changed;
   logic [irdsc_pkg::DIST_W-1:0]  sample_distance;
   logic [irdsc_pkg::DIST_W-1:0]  left_distance;
   logic [irdsc_pkg::DIST_W-1:0]  back_distance;
   logic [irdsc_pkg::DIST_W-1:0]  right_distance;
   logic [irdsc_pkg::DIST_W-1:0]  front_distance;

   modport source (output valid, channel_valid, next_channel, scan_done, changed,
                   sample_distance, left_distance, back_distance, right_distance,
                   front_distance, input ready);
   modport sink   (input valid, channel_valid, next_channel, scan_done, changed,
                   sample_distance, left_distance, back_distance, right_distance,
                   front_distance, output ready);
endinterface

interface irdsc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [irdsc_pkg::MASK_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/irdsc_ctrl.sv */
module irdsc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  irdsc_pkg::irdsc_status_type status,
   output irdsc_pkg::irdsc_cmd_type    cmd
);

   irdsc_pkg::irdsc_state_type state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irdsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one item: search, multiply, divide, commit; skipped or off-table items go to commit
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         irdsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = irdsc_pkg::ST_SEARCH;
            end
         end
         irdsc_pkg::ST_SEARCH: begin
            priority if (status.skip) begin
               state_in = irdsc_pkg::ST_COMMIT;
            end else if (status.search_done) begin
               state_in = status.in_table ? irdsc_pkg::ST_MULT : irdsc_pkg::ST_COMMIT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         irdsc_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = irdsc_pkg::ST_DIVIDE;
         end
         irdsc_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = irdsc_pkg::ST_COMMIT;
            else                 cmd.div_step = 1'b1;
         end
         irdsc_pkg::ST_COMMIT: begin
            // Wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = irdsc_pkg::ST_IDLE;
            end
         end
         default: state_in = irdsc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/irdsc_datapath.sv */
module irdsc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  irdsc_pkg::irdsc_cmd_type            cmd,
   output irdsc_pkg::irdsc_status_type         status,
   input  logic                                req_func,
   input  logic [irdsc_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                                csr_write,
   input  logic [irdsc_pkg::MASK_W-1:0]        csr_data,
   output logic                                channel_valid,
   output logic [irdsc_pkg::CHAN_W-1:0]        next_channel,
   output logic                                scan_done,
   output logic                                changed,
   output logic [irdsc_pkg::DIST_W-1:0]        sample_distance,
   output logic [irdsc_pkg::DIST_W-1:0]        left_distance,
   output logic [irdsc_pkg::DIST_W-1:0]        back_distance,
   output logic [irdsc_pkg::DIST_W-1:0]        right_distance,
   output logic [irdsc_pkg::DIST_W-1:0]        front_distance
);

   localparam int PT_CNT_W  = irdsc_pkg::PT_CNT_W;
   localparam int GAP_W     = irdsc_pkg::GAP_W;
   localparam int DROP_W    = irdsc_pkg::DROP_W;
   localparam int NUM_W     = irdsc_pkg::NUM_W;
   localparam int DIV_CNT_W = irdsc_pkg::DIV_CNT_W;
   localparam int SCAN_W    = irdsc_pkg::SCAN_W;
   localparam int DIST_W    = irdsc_pkg::DIST_W;
   localparam int SENSORS   = irdsc_pkg::SENSOR_COUNT;

   // Item and arithmetic registers
   logic                            func_ff;
   logic [irdsc_pkg::SAMPLE_W-1:0]  sample_ff;
   logic [PT_CNT_W-1:0]             k_ff;
   logic [GAP_W-1:0]                rem_ff;
   logic [NUM_W-1:0]                quo_ff;
   logic [DIV_CNT_W-1:0]            div_cnt_ff;

   // Architectural state
   logic [irdsc_pkg::MASK_W-1:0]    mask_ff;
   logic [SCAN_W-1:0]               scan_index_ff, scan_index_in;
   logic [DIST_W-1:0]               dist_store_ff [SENSORS];
   logic [DIST_W-1:0]               dist_store_in [SENSORS];
   logic                            changed_ff, changed_in;

   // Result register
   logic                            channel_valid_ff;
   logic [irdsc_pkg::CHAN_W-1:0]    next_channel_ff;
   logic                            scan_done_ff;
   logic                            changed_out_ff;
   logic [DIST_W-1:0]               sample_distance_ff;
   logic [DIST_W-1:0]               dist_out_ff [SENSORS];

   logic [PT_CNT_W-1:0]             k_prev;
   logic                            active;
   logic                            above;
   logic                            below;
   logic [GAP_W-1:0]                gap;
   logic [DROP_W-1:0]               drop;
   logic [GAP_W-1:0]                den;
   logic [GAP_W:0]                  partial;
   logic [GAP_W:0]                  trial;
   logic [DIST_W-1:0]               conv_distance;
   logic                            next_active;

   assign k_prev = k_ff - PT_CNT_W'(1);
   assign active = scan_index_ff < SCAN_W'(SENSORS);
   assign above  = k_ff == PT_CNT_W'(irdsc_pkg::TABLE_POINTS);
   assign below  = (k_ff == PT_CNT_W'(1)) && (sample_ff < irdsc_pkg::pt_reading('0));

   // Status back to the controller
   always_comb begin
      status.skip        = (func_ff == irdsc_pkg::FUNC_START) || !active;
      status.search_done = above || !(sample_ff > irdsc_pkg::pt_reading(k_ff));
      status.in_table    = !above && !below;
      status.div_done    = div_cnt_ff == '0;
   end

   // Segment operands
   assign gap  = GAP_W'(sample_ff - irdsc_pkg::pt_reading(k_prev));
   assign drop = DROP_W'(irdsc_pkg::pt_distance(k_prev) - irdsc_pkg::pt_distance(k_ff));
   assign den  = GAP_W'(irdsc_pkg::pt_reading(k_ff) - irdsc_pkg::pt_reading(k_prev));

   // Restoring divide step on the magnitude
   assign partial = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = partial - {1'b0, den};

   // Capture item, walk the table, multiply, then divide one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         sample_ff <= req_sample;
         k_ff      <= PT_CNT_W'(1);
      end
      if (cmd.search_step) k_ff <= k_ff + PT_CNT_W'(1);
      if (cmd.mult) begin
         quo_ff     <= NUM_W'(gap * drop);
         rem_ff     <= '0;
         div_cnt_ff <= DIV_CNT_W'(NUM_W);
      end
      if (cmd.div_step) begin
         if (partial >= {1'b0, den}) begin
            rem_ff <= trial[GAP_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= partial[GAP_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   // Converted distance of this item
   always_comb begin
      priority if (status.skip) conv_distance = '0;
      else if (below)           conv_distance = irdsc_pkg::DIST_BELOW_RANGE;
      else if (above)
         conv_distance = irdsc_pkg::pt_distance(PT_CNT_W'(irdsc_pkg::TABLE_POINTS - 1));
      else
         conv_distance = irdsc_pkg::pt_distance(k_prev) - DIST_W'(quo_ff);
   end

   // Next scan state
   always_comb begin
      scan_index_in = scan_index_ff;
      changed_in    = changed_ff;
      for (int i = 0; i < SENSORS; i++) dist_store_in[i] = dist_store_ff[i];
      priority if (func_ff == irdsc_pkg::FUNC_START) begin
         scan_index_in = irdsc_pkg::first_enabled(mask_ff, '0);
         if (scan_index_in < SCAN_W'(SENSORS)) changed_in = 1'b0;
      end else if (active) begin
         if (dist_store_ff[scan_index_ff[SCAN_W-2:0]] != conv_distance) begin
            dist_store_in[scan_index_ff[SCAN_W-2:0]] = conv_distance;
            changed_in = 1'b1;
         end
         scan_index_in = irdsc_pkg::first_enabled(mask_ff, scan_index_ff + SCAN_W'(1));
      end
      next_active = scan_index_in < SCAN_W'(SENSORS);
   end

   // Commit state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '1;
         scan_index_ff <= SCAN_W'(SENSORS);
         changed_ff    <= 1'b0;
         for (int i = 0; i < SENSORS; i++) dist_store_ff[i] <= '0;
      end else begin
         if (csr_write) mask_ff <= csr_data;
         if (cmd.commit) begin
            scan_index_ff <= scan_index_in;
            changed_ff    <= changed_in;
            for (int i = 0; i < SENSORS; i++) dist_store_ff[i] <= dist_store_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         channel_valid_ff   <= next_active;
         next_channel_ff    <= next_active ? scan_index_in[irdsc_pkg::CHAN_W-1:0] : '0;
         scan_done_ff       <= (func_ff == irdsc_pkg::FUNC_SAMPLE) && active && !next_active;
         changed_out_ff     <= changed_in;
         sample_distance_ff <= conv_distance;
         for (int i = 0; i < SENSORS; i++) dist_out_ff[i] <= dist_store_in[i];
      end
   end

   assign channel_valid   = channel_valid_ff;
   assign next_channel    = next_channel_ff;
   assign scan_done       = scan_done_ff;
   assign changed         = changed_out_ff;
   assign sample_distance = sample_distance_ff;
   assign left_distance   = dist_out_ff[0];
   assign back_distance   = dist_out_ff[1];
   assign right_distance  = dist_out_ff[2];
   assign front_distance  = dist_out_ff[3];

endmodule

/* rtl/ir_distance_scan_converter.sv */
// A start item or an ignored sample goes from the transfer straight to its commit; a sample
// inside the table walks the table, takes a multiply step, the divide steps and a finish
// step and commits; below range after the first compare, past the table after the full walk.
// Throughput: one item at a time; the next transfer is taken once the commit is done,
// while the previous result may still wait in the output register.
// Reset (synchronous, active high): mask all enabled, no scan active, distances and flag zero.
module ir_distance_scan_converter (
   input  logic        clock,
   input  logic        reset,
   irdsc_req_if.sink   req_chan,
   irdsc_rsp_if.source rsp_chan,
   irdsc_csr_if.sink   csr_chan
);

   irdsc_pkg::irdsc_cmd_type    cmd;
   irdsc_pkg::irdsc_status_type status;

   // Mask register always accepts a write
   assign csr_chan.ready = 1'b1;

   irdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   irdsc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_chan.func),
      .req_sample      (req_chan.sample),
      .csr_write       (csr_chan.valid),
      .csr_data        (csr_chan.data),
      .channel_valid   (rsp_chan.channel_valid),
      .next_channel    (rsp_chan.next_channel),
      .scan_done       (rsp_chan.scan_done),
      .changed         (rsp_chan.changed),
      .sample_distance (rsp_chan.sample_distance),
      .left_distance   (rsp_chan.left_distance),
      .back_distance   (rsp_chan.back_distance),
      .right_distance  (rsp_chan.right_distance),
      .front_distance  (rsp_chan.front_distance)
   );

endmodule

/* rtl/irdsc_checker.sv */
`include "ir_distance_scan_converter_defines.svh"

module irdsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        channel_valid,
   input logic [irdsc_pkg::CHAN_W-1:0] next_channel,
   input logic                        scan_done,
   input logic [irdsc_pkg::DIST_W-1:0] sample_distance
);

   // Stalled result holds
   `IRDSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(sample_distance))
   // One item at a time: no transfer right after a transfer
   `IRDSC_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)
   // A finished scan leaves no channel selected
   `IRDSC_ASSERT_NOW(a_done_idle, rsp_valid && scan_done, !channel_valid)
   // No channel selected reads as channel zero
   `IRDSC_ASSERT_NOW(a_chan_zero, rsp_valid && !channel_valid, next_channel == '0)

endmodule

bind ir_distance_scan_converter irdsc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .channel_valid   (rsp_chan.channel_valid),
   .next_channel    (rsp_chan.next_channel),
   .scan_done       (rsp_chan.scan_done),
   .sample_distance (rsp_chan.sample_distance)
);

/* tb/ir_distance_scan_converter_test.sv */
import irdsc_pkg::*;

// One result transfer, field for field as the result channel carries it
typedef struct packed {
   logic              channel_valid;
   logic [CHAN_W-1:0] next_channel;
   logic              scan_done;
   logic              changed;
   logic [DIST_W-1:0] sample_distance;
   logic [DIST_W-1:0] left_distance;
   logic [DIST_W-1:0] back_distance;
   logic [DIST_W-1:0] right_distance;
   logic [DIST_W-1:0] front_distance;
} scan_reading_type;

// Tracks the scan state, predicts each result and compares what comes out
class distance_scoreboard;
   logic [MASK_W-1:0] sensor_mask;
   int unsigned       scan_pos;
   logic [DIST_W-1:0] stored_cm [SENSOR_COUNT];
   logic              any_change;
   scan_reading_type  expected_readings [$];
   int unsigned       mismatches;

   function new();
      sensor_mask = '1;
      scan_pos    = SENSOR_COUNT;
      foreach (stored_cm[i]) stored_cm[i] = '0;
      any_change  = 1'b0;
      mismatches  = 0;
   endfunction

   // Calibration curve: reading and distance of point k
   static function void cal_point(input int k, output int rd, output int cm);
      case (k)
         0:       begin rd = 60;  cm = 40; end
         1:       begin rd = 88;  cm = 30; end
         2:       begin rd = 107; cm = 25; end
         3:       begin rd = 151; cm = 20; end
         4:       begin rd = 165; cm = 16; end
         5:       begin rd = 189; cm = 14; end
         6:       begin rd = 215; cm = 12; end
         7:       begin rd = 257; cm = 10; end
         8:       begin rd = 287; cm = 9;  end
         9:       begin rd = 319; cm = 8;  end
         10:      begin rd = 360; cm = 7;  end
         11:      begin rd = 410; cm = 6;  end
         12:      begin rd = 480; cm = 5;  end
         default: begin rd = 559; cm = 4;  end
      endcase
   endfunction

   // Interpolate within the segment holding v; int division truncates toward zero
   function int reading_to_cm(int v);
      int x0, x1, c0, c1;
      cal_point(0, x0, c0);
      if (v < x0) return int'(DIST_BELOW_RANGE);
      for (int k = 1; k < TABLE_POINTS; k++) begin
         cal_point(k, x1, c1);
         if (v <= x1) return c0 + ((v - x0) * (c1 - c0)) / (x1 - x0);
         x0 = x1;
         c0 = c1;
      end
      // Past the last point: hold its distance
      return c0;
   endfunction

   function int unsigned first_on(int unsigned from);
      for (int unsigned i = from; i < SENSOR_COUNT; i++) begin
         if (sensor_mask[i]) return i;
      end
      return SENSOR_COUNT;
   endfunction

   function string show(scan_reading_type r);
      return $sformatf("chv=%0d next=%0d done=%0d chg=%0d cm=%0d store=%0d/%0d/%0d/%0d",
                       r.channel_valid, r.next_channel, r.scan_done, r.changed,
                       r.sample_distance, r.left_distance, r.back_distance,
                       r.right_distance, r.front_distance);
   endfunction

   // Advance the scan state for one accepted item and queue its result
   function void note_item(logic f, logic [SAMPLE_W-1:0] s);
      scan_reading_type  want;
      logic [DIST_W-1:0] cm;
      want = '0;
      if (f == FUNC_START) begin
         scan_pos = first_on(0);
         if (scan_pos < SENSOR_COUNT) any_change = 1'b0;
      end else if (scan_pos < SENSOR_COUNT) begin
         cm = DIST_W'(reading_to_cm(int'(s)));
         want.sample_distance = cm;
         if (stored_cm[scan_pos] != cm) begin
            stored_cm[scan_pos] = cm;
            any_change = 1'b1;
         end
         scan_pos = first_on(scan_pos + 1);
         want.scan_done = (scan_pos >= SENSOR_COUNT);
      end
      want.channel_valid  = (scan_pos < SENSOR_COUNT);
      want.next_channel   = want.channel_valid ? CHAN_W'(scan_pos) : '0;
      want.changed        = any_change;
      want.left_distance  = stored_cm[0];
      want.back_distance  = stored_cm[1];
      want.right_distance = stored_cm[2];
      want.front_distance = stored_cm[3];
      expected_readings.push_back(want);
   endfunction

   // Compare one result transfer with the oldest prediction
   function void check_reading(scan_reading_type got);
      scan_reading_type want;
      if (expected_readings.size() == 0) begin
         if (mismatches < 10) $display("unexpected result: %s", show(got));
         mismatches++;
         return;
      end
      want = expected_readings.pop_front();
      if (got.channel_valid !== want.channel_valid || got.next_channel !== want.next_channel ||
          got.scan_done !== want.scan_done || got.changed !== want.changed ||
          got.sample_distance !== want.sample_distance ||
          got.left_distance !== want.left_distance ||
          got.back_distance !== want.back_distance ||
          got.right_distance !== want.right_distance ||
          got.front_distance !== want.front_distance) begin
         if (mismatches < 10) begin
            $display("result mismatch: expected %s", show(want));
            $display("                 actual   %s", show(got));
         end
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return expected_readings.size();
   endfunction
endclass

module ir_distance_scan_converter_test;

   localparam int HALF_PERIOD   = 2;
   localparam int IDLE_LIMIT    = 2000;
   localparam int TARGET_ITEMS  = 1100;
   localparam int SETTLE_CYCLES = 40;
   localparam int CSR_PAUSE     = 8;

   logic clock;
   logic reset;

   irdsc_req_if req_chan ();
   irdsc_rsp_if rsp_chan ();
   irdsc_csr_if csr_chan ();

   ir_distance_scan_converter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   distance_scoreboard  sb;
   int unsigned         burst_left;
   int unsigned         sent_items;
   int unsigned         idle_cycles;
   logic [SAMPLE_W-1:0] last_reading [SENSOR_COUNT];

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Receiver: check every result transfer, stall on a rotating pattern
   initial begin
      logic [15:0] stall_word;
      int unsigned stall_phase;
      stall_word  = '1;
      stall_phase = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               sb.check_reading(scan_reading_type'{
                  channel_valid:   rsp_chan.channel_valid,
                  next_channel:    rsp_chan.next_channel,
                  scan_done:       rsp_chan.scan_done,
                  changed:         rsp_chan.changed,
                  sample_distance: rsp_chan.sample_distance,
                  left_distance:   rsp_chan.left_distance,
                  back_distance:   rsp_chan.back_distance,
                  right_distance:  rsp_chan.right_distance,
                  front_distance:  rsp_chan.front_distance});
            end
            // Pick a new pattern each time the phase counter wraps
            if (stall_phase == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_word = '1;
                  1:       stall_word = 16'($urandom);
                  2:       stall_word = 16'h0101;
                  default: stall_word = 16'($urandom) | 16'hF0F0;
               endcase
            end
            stall_phase = (stall_phase + 1) % 32;
            stall_word  = {stall_word[0], stall_word[15:1]};
            rsp_chan.ready <= stall_word[0];
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Send one item, opening a new burst after a random gap when the last one ran out
   task automatic send_item(input logic f, input logic [SAMPLE_W-1:0] s);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid  <= 1'b1;
      req_chan.func   <= f;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      if (f == FUNC_START || sb.scan_pos < SENSOR_COUNT) sent_items++;
      sb.note_item(f, s);
   endtask

   // Drain all results, hold off, then write the sensor mask
   task automatic write_mask(input logic [MASK_W-1:0] m);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (CSR_PAUSE) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= m;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      sb.sensor_mask = m;
   endtask

   // Reading for the sensor now selected: often a repeat, often a table point
   function automatic logic [SAMPLE_W-1:0] pick_reading();
      logic [SAMPLE_W-1:0] r;
      int unsigned         roll;
      int                  rd, cm;
      roll = $urandom_range(0, 99);
      if (roll < 30 && sb.scan_pos < SENSOR_COUNT) begin
         r = last_reading[sb.scan_pos];
      end else if (roll < 45) begin
         sb.cal_point($urandom_range(0, TABLE_POINTS - 1), rd, cm);
         r = SAMPLE_W'(rd);
      end else if (roll < 75) begin
         r = SAMPLE_W'($urandom_range(50, 600));
      end else if (roll < 85) begin
         case ($urandom_range(0, 5))
            0:       r = 10'd0;
            1:       r = 10'd59;
            2:       r = 10'd60;
            3:       r = 10'd559;
            4:       r = 10'd560;
            default: r = 10'd1023;
         endcase
      end else begin
         r = SAMPLE_W'($urandom_range(0, 1023));
      end
      if (sb.scan_pos < SENSOR_COUNT) last_reading[sb.scan_pos] = r;
      return r;
   endfunction

   // One scan: mostly complete, sometimes cut short, padded or preceded by stray samples
   task automatic run_scan();
      int unsigned n;
      int unsigned style;
      style = $urandom_range(0, 9);
      if (style == 0) repeat ($urandom_range(1, 2)) send_item(FUNC_SAMPLE, pick_reading());
      send_item(FUNC_START, SAMPLE_W'($urandom_range(0, 1023)));
      n = $countones(sb.sensor_mask);
      if (style == 1 && n > 0) n = $urandom_range(0, n - 1);
      else if (style == 2) n += $urandom_range(1, 2);
      repeat (n) send_item(FUNC_SAMPLE, pick_reading());
   endtask

   // Main sequence
   initial begin
      int unsigned       phase;
      int unsigned       phase_end;
      logic [MASK_W-1:0] m;

      sb = new();
      burst_left = 0;
      sent_items = 0;
      foreach (last_reading[i]) last_reading[i] = '0;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.func   <= FUNC_START;
      req_chan.sample <= '0;
      csr_chan.valid  <= 1'b0;
      csr_chan.data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sample with no scan, then a full scan over the range edges
      send_item(FUNC_SAMPLE, 10'd512);
      send_item(FUNC_START, 10'd0);
      send_item(FUNC_SAMPLE, 10'd0);
      send_item(FUNC_SAMPLE, 10'd59);
      send_item(FUNC_SAMPLE, 10'd60);
      send_item(FUNC_SAMPLE, 10'd1023);
      send_item(FUNC_SAMPLE, 10'd341);

      // Empty mask: start selects nothing and keeps the changed flag
      write_mask(4'h0);
      send_item(FUNC_START, 10'd1023);
      send_item(FUNC_SAMPLE, 10'd682);

      // Changed scan, then the same readings again so nothing changes
      write_mask(4'hF);
      repeat (2) begin
         send_item(FUNC_START, 10'd0);
         send_item(FUNC_SAMPLE, 10'd559);
         send_item(FUNC_SAMPLE, 10'd560);
         send_item(FUNC_SAMPLE, 10'd88);
         send_item(FUNC_SAMPLE, 10'd1022);
      end

      // Rewrite the mask halfway through a scan
      send_item(FUNC_START, 10'd0);
      send_item(FUNC_SAMPLE, 10'd480);
      send_item(FUNC_SAMPLE, 10'd300);
      write_mask(4'b1010);
      send_item(FUNC_SAMPLE, 10'd410);
      send_item(FUNC_SAMPLE, 10'd151);

      // Random phases, each under its own mask
      phase = 0;
      while (sent_items < TARGET_ITEMS) begin
         case (phase)
            0:       m = 4'hF;
            1:       m = 4'h0;
            2:       m = 4'h1;
            3:       m = 4'h8;
            default: m = MASK_W'($urandom_range(0, 15));
         endcase
         write_mask(m);
         phase_end = sent_items + ((m == 4'h0) ? 15 : $urandom_range(60, 140));
         while (sent_items < phase_end) run_scan();
         // Leave a scan open now and then so the next mask lands mid-scan
         if (m != 4'h0 && $urandom_range(0, 1) == 1) begin
            send_item(FUNC_START, SAMPLE_W'($urandom_range(0, 1023)));
            send_item(FUNC_SAMPLE, pick_reading());
         end
         phase++;
      end

      // Drain, let stray results show up, then report
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
